/* design/vector3_accumulator_alu_defines.svh */
// Assertion macros shared by the checkers of the vector accumulator ALU.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef VECTOR3_ACCUMULATOR_ALU_DEFINES_SVH
`define VECTOR3_ACCUMULATOR_ALU_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define VAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

/* design/vac_pkg.sv */
// Shared types, codes and helpers of the vector accumulator ALU.
// Used by the lane, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package vac_pkg;

    // Action codes of an input beat.
    localparam logic [3:0] ACT_LOAD    = 4'd0;
    localparam logic [3:0] ACT_ADD     = 4'd1;
    localparam logic [3:0] ACT_SUB     = 4'd2;
    localparam logic [3:0] ACT_SCALE   = 4'd3;
    localparam logic [3:0] ACT_DIVIDE  = 4'd4;
    localparam logic [3:0] ACT_CROSS   = 4'd5;
    localparam logic [3:0] ACT_MODULO  = 4'd6;
    localparam logic [3:0] ACT_INC     = 4'd7;
    localparam logic [3:0] ACT_DEC     = 4'd8;
    localparam logic [3:0] ACT_NEGATE  = 4'd9;
    localparam logic [3:0] ACT_COMPARE = 4'd10;
    localparam logic [3:0] ACT_READ    = 4'd11;

    // Sticky status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_MOD_ZERO = 2'd2;
    localparam logic [1:0] ST_BAD_IDX  = 2'd3;

    // Component index that selects nothing valid.
    localparam logic [1:0] IDX_BAD     = 2'd3;

    // Operation carried out by one lane.
    typedef enum logic [2:0] {
        LOP_ADD,
        LOP_SUB,
        LOP_MUL,
        LOP_DIV,
        LOP_MOD
    } t_lane_op;

    // Command from the top level to one lane.
    typedef struct packed {
        logic               start;
        t_lane_op           op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } t_lane_cmd;

    // Input beat.
    typedef struct packed {
        logic        [3:0]  action;
        logic signed [31:0] op_x;
        logic signed [31:0] op_y;
        logic signed [31:0] op_z;
        logic signed [31:0] scalar;
        logic signed [15:0] int_divisor;
        logic        [1:0]  index;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic               equal;
        logic               any_nonzero;
        logic signed [31:0] component;
        logic        [1:0]  status;
    } t_out_beat;

    // Saturate a wide signed value to the 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v[64] && !(&v[63:31])) begin
            r = 32'sh8000_0000;
        end else if (!v[64] && (|v[63:31])) begin
            r = 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/vac_lane.sv */
// One arithmetic lane of the vector accumulator ALU: add, subtract,
// difference of two products, and a restoring divider for divide and modulo.
// Depends on vac_pkg.
`timescale 1ns / 1ps

module vac_lane
    import vac_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_cmd          i_cmd,
    output logic               o_done,
    output logic signed [31:0] o_res
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL2,
        L_MULF,
        L_DIV,
        L_FIN
    } t_lstate;

    t_lstate            r_state;
    logic               r_done;
    logic signed [31:0] r_res;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_p2;
    logic signed [31:0] r_c;
    logic signed [31:0] r_d;
    t_lane_op           r_op;
    logic               r_neg;
    logic [DW-1:0]      r_dvd;
    logic [31:0]        r_div;
    logic [31:0]        r_rem;
    logic [CW-1:0]      r_cnt;

    logic        [31:0] mag_a;
    logic        [31:0] mag_b;
    logic signed [32:0] s_add;
    logic signed [32:0] s_sub;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic        [32:0] rem_sh;
    logic               ge;
    logic        [32:0] rem_dif;
    logic        [31:0] n_rem;
    logic signed [64:0] diff;
    logic signed [64:0] diff_sh;
    logic signed [64:0] q_wide;
    logic signed [64:0] r_wide;
    logic signed [64:0] fin_val;

    // Operand magnitudes and the narrow sums.
    always_comb begin
        mag_a = i_cmd.a[31] ? (~i_cmd.a + 32'd1) : i_cmd.a;
        mag_b = i_cmd.b[31] ? (~i_cmd.b + 32'd1) : i_cmd.b;
        s_add = {i_cmd.a[31], i_cmd.a} + {i_cmd.b[31], i_cmd.b};
        s_sub = {i_cmd.a[31], i_cmd.a} - {i_cmd.b[31], i_cmd.b};
    end

    // The single multiplier takes the first pair at the start and the second pair next.
    always_comb begin
        mul_a = (r_state == L_MUL2) ? r_c : i_cmd.a;
        mul_b = (r_state == L_MUL2) ? r_d : i_cmd.b;
        prod  = mul_a * mul_b;
    end

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DW-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_dif = rem_sh - {1'b0, r_div};
        n_rem   = ge ? rem_dif[31:0] : rem_sh[31:0];
    end

    // Product difference, floored to the fixed-point scale.
    always_comb begin
        diff    = {r_p1[63], r_p1} - {r_p2[63], r_p2};
        diff_sh = diff >>> FRAC_BITS;
    end

    // Sign fix-up of the quotient or the remainder.
    always_comb begin
        q_wide = 65'(r_dvd);
        r_wide = 65'(r_rem);
        if (r_op == LOP_DIV) begin
            fin_val = r_neg ? -q_wide : q_wide;
        end else begin
            fin_val = (r_neg ? -r_wide : r_wide) <<< FRAC_BITS;
        end
    end

    // Lane sequencer and its registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_cmd.start) begin
                        r_op <= i_cmd.op;
                        case (i_cmd.op)
                            LOP_ADD: begin
                                r_res  <= sat32({{32{s_add[32]}}, s_add});
                                r_done <= 1'b1;
                            end
                            LOP_SUB: begin
                                r_res  <= sat32({{32{s_sub[32]}}, s_sub});
                                r_done <= 1'b1;
                            end
                            LOP_MUL: begin
                                r_p1    <= prod;
                                r_c     <= i_cmd.c;
                                r_d     <= i_cmd.d;
                                r_done  <= 1'b0;
                                r_state <= L_MUL2;
                            end
                            LOP_DIV: begin
                                r_dvd   <= DW'(mag_a) << FRAC_BITS;
                                r_div   <= mag_b;
                                r_neg   <= i_cmd.a[31] ^ i_cmd.b[31];
                                r_rem   <= '0;
                                r_cnt   <= CW'(DW);
                                r_done  <= 1'b0;
                                r_state <= L_DIV;
                            end
                            LOP_MOD: begin
                                r_dvd   <= DW'(mag_a >> FRAC_BITS);
                                r_div   <= mag_b;
                                r_neg   <= i_cmd.a[31];
                                r_rem   <= '0;
                                r_cnt   <= CW'(DW);
                                r_done  <= 1'b0;
                                r_state <= L_DIV;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end else begin
                        r_done <= 1'b0;
                    end
                end
                L_MUL2: begin
                    r_p2    <= prod;
                    r_state <= L_MULF;
                end
                L_MULF: begin
                    r_res   <= sat32(diff_sh);
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                L_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[DW-2:0], ge};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= L_FIN;
                    end
                end
                L_FIN: begin
                    r_res   <= sat32(fin_val);
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* design/vector3_accumulator_alu.sv */
// Three-component Q16.16 accumulator ALU with a sticky status: one result beat
// per input beat. An input beat is taken only while no earlier beat is in
// work. Load, compare, read, unused actions and rejected divides or modulos
// skip the lanes and go straight to write-back; add, subtract, increment,
// decrement and negate finish in the lane at its start; scale and cross product
// take two multiplies that share each lane's multiplier; divide and modulo use
// the restoring divider in each lane that retires one quotient bit a cycle. Three lanes, one per
// component, run in parallel, and the result stage merges their outputs with
// the flags.
`timescale 1ns / 1ps

module vector3_accumulator_alu
    import vac_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WB
    } t_state;

    t_state             r_state;
    t_in_beat           r_item;
    logic               r_use_lane;
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_lres [3];
    logic        [1:0]  r_status;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               accept;
    logic               need_lane;
    t_lane_op           lop;
    logic signed [31:0] op_v [3];
    t_lane_cmd          cmd [3];
    logic        [2:0]  done;
    logic signed [31:0] lres [3];
    logic               wb_go;
    logic signed [31:0] n_acc [3];
    logic        [1:0]  n_status;
    t_out_beat          n_out;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign op_v[0] = i_data.op_x;
    assign op_v[1] = i_data.op_y;
    assign op_v[2] = i_data.op_z;

    // Decide whether the beat needs the lanes and which lane operation.
    always_comb begin
        need_lane = 1'b1;
        lop       = LOP_ADD;
        case (i_data.action)
            ACT_ADD:    lop = LOP_ADD;
            ACT_INC:    lop = LOP_ADD;
            ACT_SUB:    lop = LOP_SUB;
            ACT_DEC:    lop = LOP_SUB;
            ACT_NEGATE: lop = LOP_SUB;
            ACT_SCALE:  lop = LOP_MUL;
            ACT_CROSS:  lop = LOP_MUL;
            ACT_DIVIDE: begin
                lop       = LOP_DIV;
                need_lane = (i_data.scalar != 32'sd0);
            end
            ACT_MODULO: begin
                lop       = LOP_MOD;
                need_lane = (i_data.int_divisor != 16'sd0);
            end
            default:    need_lane = 1'b0;
        endcase
    end

    // Lane commands: component k works on its own accumulator value, but a cross product uses the other two.
    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        always_comb begin
            cmd[k].start = accept && need_lane;
            cmd[k].op    = lop;
            cmd[k].a     = r_acc[k];
            cmd[k].b     = op_v[k];
            cmd[k].c     = 32'sd0;
            cmd[k].d     = 32'sd0;
            case (i_data.action)
                ACT_INC:    cmd[k].b = ONE;
                ACT_DEC:    cmd[k].b = ONE;
                ACT_NEGATE: begin
                    cmd[k].a = 32'sd0;
                    cmd[k].b = r_acc[k];
                end
                ACT_SCALE:  cmd[k].b = i_data.scalar;
                ACT_DIVIDE: cmd[k].b = i_data.scalar;
                ACT_MODULO: cmd[k].b = 32'(i_data.int_divisor);
                ACT_CROSS: begin
                    cmd[k].a = r_acc[K1];
                    cmd[k].b = op_v[K2];
                    cmd[k].c = r_acc[K2];
                    cmd[k].d = op_v[K1];
                end
                default:    cmd[k].b = op_v[k];
            endcase
        end

        vac_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (cmd[k]),
            .o_done (done[k]),
            .o_res  (lres[k])
        );
    end

    // Merge stage: new accumulator, status and the result flags.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_acc[k] = r_use_lane ? r_lres[k] : r_acc[k];
        end
        n_status = r_status;
        case (r_item.action)
            ACT_LOAD: begin
                n_acc[0] = r_item.op_x;
                n_acc[1] = r_item.op_y;
                n_acc[2] = r_item.op_z;
                n_status = ST_OK;
            end
            ACT_DIVIDE: if (!r_use_lane) n_status = ST_DIV_ZERO;
            ACT_MODULO: if (!r_use_lane) n_status = ST_MOD_ZERO;
            ACT_READ:   if (r_item.index == IDX_BAD) n_status = ST_BAD_IDX;
            default:    n_status = r_status;
        endcase
        n_out.res_x       = n_acc[0];
        n_out.res_y       = n_acc[1];
        n_out.res_z       = n_acc[2];
        n_out.equal       = (n_acc[0] == r_item.op_x) && (n_acc[1] == r_item.op_y)
                            && (n_acc[2] == r_item.op_z);
        n_out.any_nonzero = (n_acc[0] != 32'sd0) || (n_acc[1] != 32'sd0)
                            || (n_acc[2] != 32'sd0);
        case (r_item.index)
            2'd0:    n_out.component = n_acc[0];
            2'd1:    n_out.component = n_acc[1];
            default: n_out.component = n_acc[2];
        endcase
        n_out.status = n_status;
    end

    assign wb_go = (r_state == S_WB) && (!r_out_valid || !i_stall);

    // Control sequence, accumulator and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= 32'sd0;
            end
        end else begin
            // The output register fills on write-back and empties when taken.
            if (wb_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item     <= i_data;
                        r_use_lane <= need_lane;
                        r_state    <= need_lane ? S_RUN : S_WB;
                    end
                end
                S_RUN: begin
                    if (&done) begin
                        for (int k = 0; k < 3; k++) begin
                            r_lres[k] <= lres[k];
                        end
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (wb_go) begin
                        for (int k = 0; k < 3; k++) begin
                            r_acc[k] <= n_acc[k];
                        end
                        r_status <= n_status;
                        r_out    <= n_out;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* design/vac_checker.sv */
// Port-level checker of the vector accumulator ALU, bound to the top level.
// Depends on vac_pkg and vector3_accumulator_alu_defines.svh.
`timescale 1ns / 1ps
`include "vector3_accumulator_alu_defines.svh"

module vac_port_checker
    import vac_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_beat o_data
);

    // A result beat held back by the receiver stays unchanged.
    `VAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

    // Once a beat is taken, the block is busy in the following cycle.
    `VAC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // A new result only appears when a beat was in work.
    `VAC_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

    // The nonzero flag agrees with the reported accumulator.
    `VAC_ASSERT_NOW(a_nonzero_flag, i_clk, i_rst_n, o_valid,
        o_data.any_nonzero == ((o_data.res_x != 0) || (o_data.res_y != 0) || (o_data.res_z != 0)))

endmodule

bind vector3_accumulator_alu vac_port_checker u_vac_checker (.*);

/* test/vac_checker.sv */
// Scoreboard for the vector accumulator ALU: predicts each result beat and compares it.
// Depends on vac_pkg for the beat types and the action and status codes.
`timescale 1ns / 1ps

module vac_checker
    import vac_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_stall_in,
    input  t_in_beat  i_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_errors,
    output int        o_pending
);

    // Predicted accumulator and sticky status.
    logic signed [31:0] acc_x, acc_y, acc_z;
    logic        [1:0]  status_q;
    t_out_beat          expected_beats[$];
    int                 err_count;

    assign o_errors  = err_count;
    assign o_pending = expected_beats.size();

    function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
        logic signed [31:0] r;
        if (v > 128'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -128'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Arithmetic shift of a signed value rounds toward minus infinity.
    function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clip32(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] fix_div(input logic signed [31:0] a,
                                                   input logic signed [31:0] s);
        logic signed [127:0] n;
        n = 128'(a) <<< FRAC_BITS;
        return clip32(n / 128'(s));
    endfunction

    function automatic logic signed [31:0] cross_part(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic signed [31:0] c,
                                                      input logic signed [31:0] d);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b) - 128'(c) * 128'(d);
        return clip32(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] int_mod(input logic signed [31:0] a,
                                                   input logic signed [15:0] d);
        logic signed [127:0] ip, r;
        ip = 128'(a) / (128'sd1 <<< FRAC_BITS);
        r  = ip % 128'(d);
        return clip32(r <<< FRAC_BITS);
    endfunction

    // Advance the predicted state by one input beat and return its result.
    function automatic t_out_beat predict_result(input t_in_beat b);
        t_out_beat          r;
        logic signed [31:0] nx, ny, nz;
        logic signed [127:0] one;
        one = 128'sd1 <<< FRAC_BITS;
        case (b.action)
            ACT_LOAD: begin
                acc_x = b.op_x; acc_y = b.op_y; acc_z = b.op_z;
                status_q = ST_OK;
            end
            ACT_ADD: begin
                acc_x = clip32(128'(acc_x) + 128'(b.op_x));
                acc_y = clip32(128'(acc_y) + 128'(b.op_y));
                acc_z = clip32(128'(acc_z) + 128'(b.op_z));
            end
            ACT_SUB: begin
                acc_x = clip32(128'(acc_x) - 128'(b.op_x));
                acc_y = clip32(128'(acc_y) - 128'(b.op_y));
                acc_z = clip32(128'(acc_z) - 128'(b.op_z));
            end
            ACT_SCALE: begin
                acc_x = fix_mul(acc_x, b.scalar);
                acc_y = fix_mul(acc_y, b.scalar);
                acc_z = fix_mul(acc_z, b.scalar);
            end
            ACT_DIVIDE: begin
                if (b.scalar == 0) begin
                    status_q = ST_DIV_ZERO;
                end else begin
                    acc_x = fix_div(acc_x, b.scalar);
                    acc_y = fix_div(acc_y, b.scalar);
                    acc_z = fix_div(acc_z, b.scalar);
                end
            end
            ACT_CROSS: begin
                nx = cross_part(acc_y, b.op_z, acc_z, b.op_y);
                ny = cross_part(acc_z, b.op_x, acc_x, b.op_z);
                nz = cross_part(acc_x, b.op_y, acc_y, b.op_x);
                acc_x = nx; acc_y = ny; acc_z = nz;
            end
            ACT_MODULO: begin
                if (b.int_divisor == 0) begin
                    status_q = ST_MOD_ZERO;
                end else begin
                    acc_x = int_mod(acc_x, b.int_divisor);
                    acc_y = int_mod(acc_y, b.int_divisor);
                    acc_z = int_mod(acc_z, b.int_divisor);
                end
            end
            ACT_INC: begin
                acc_x = clip32(128'(acc_x) + one);
                acc_y = clip32(128'(acc_y) + one);
                acc_z = clip32(128'(acc_z) + one);
            end
            ACT_DEC: begin
                acc_x = clip32(128'(acc_x) - one);
                acc_y = clip32(128'(acc_y) - one);
                acc_z = clip32(128'(acc_z) - one);
            end
            ACT_NEGATE: begin
                acc_x = clip32(-128'(acc_x));
                acc_y = clip32(-128'(acc_y));
                acc_z = clip32(-128'(acc_z));
            end
            ACT_READ: begin
                if (b.index == IDX_BAD) status_q = ST_BAD_IDX;
            end
            default: begin
            end
        endcase
        r.res_x       = acc_x;
        r.res_y       = acc_y;
        r.res_z       = acc_z;
        r.equal       = (acc_x == b.op_x) && (acc_y == b.op_y) && (acc_z == b.op_z);
        r.any_nonzero = (acc_x != 0) || (acc_y != 0) || (acc_z != 0);
        r.component   = (b.index == 2'd0) ? acc_x : (b.index == 2'd1) ? acc_y : acc_z;
        r.status      = status_q;
        return r;
    endfunction

    // Watch both channels at each rising edge.
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (!i_rst_n) begin
            acc_x <= 0; acc_y <= 0; acc_z <= 0;
            status_q <= ST_OK;
            err_count <= 0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    err_count <= err_count + 1;
                    if (err_count < 10) $display("unexpected result beat %h", i_out_data);
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (exp_beat !== i_out_data) begin
                        err_count <= err_count + 1;
                        if (err_count < 10) begin
                            $display("mismatch: x %h/%h y %h/%h z %h/%h eq %b/%b nz %b/%b",
                                     exp_beat.res_x, i_out_data.res_x,
                                     exp_beat.res_y, i_out_data.res_y,
                                     exp_beat.res_z, i_out_data.res_z,
                                     exp_beat.equal, i_out_data.equal,
                                     exp_beat.any_nonzero, i_out_data.any_nonzero);
                            $display("          comp %h/%h status %0d/%0d",
                                     exp_beat.component, i_out_data.component,
                                     exp_beat.status, i_out_data.status);
                        end
                    end
                end
            end
            if (i_valid && !i_stall_in) expected_beats.push_back(predict_result(i_data));
        end
    end

endmodule

/* test/tb.sv */
// Stimulus and verdict for the vector accumulator ALU, with vac_checker beside it.
// Depends on vac_pkg, vac_checker and the block itself.
`timescale 1ns / 1ps

module tb;
    import vac_pkg::*;

    localparam int  N_RANDOM    = 1400;
    localparam int  CYCLE_LIMIT = 900000;

    logic      clk, rst_n;
    logic      in_valid, in_stall, out_valid, out_stall;
    t_in_beat  in_beat;
    t_out_beat out_beat;
    int        errors, pending, cycles;
    bit        idle_allowed, hold_request;

    vector3_accumulator_alu uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_beat),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_beat)
    );

    vac_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_data(in_beat),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_beat),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Cycle guard against a hung block.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stalls in random bursts, or for a long stretch on request.
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 0;
            end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [31:0] pick_word();
        logic signed [31:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'sh7fff_ffff;
            1: w = 32'sh8000_0000;
            2: w = 0;
            3: w = $signed($urandom_range(0, 8)) <<< 16;
            4: w = -($signed($urandom_range(0, 8)) <<< 16);
            5: w = $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic t_in_beat random_beat();
        t_in_beat b;
        b.action      = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                     : 4'($urandom_range(0, 11));
        b.op_x        = pick_word();
        b.op_y        = pick_word();
        b.op_z        = pick_word();
        b.scalar      = ($urandom_range(0, 9) == 0) ? 0 : pick_word();
        case ($urandom_range(0, 4))
            0: b.int_divisor = 0;
            1: b.int_divisor = 16'($urandom_range(1, 9));
            2: b.int_divisor = -16'($urandom_range(1, 9));
            default: b.int_divisor = 16'($urandom);
        endcase
        b.index       = 2'($urandom_range(0, 3));
        return b;
    endfunction

    // Offer one beat, with an optional random gap first, and wait until taken.
    task automatic send_beat(input t_in_beat b);
        if (idle_allowed && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_beat  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_op(input logic [3:0] act, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z,
                           input logic signed [31:0] s, input logic signed [15:0] d,
                           input logic [1:0] idx);
        t_in_beat b;
        b = '{action: act, op_x: x, op_y: y, op_z: z, scalar: s,
              int_divisor: d, index: idx};
        send_beat(b);
    endtask

    initial begin
        localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        localparam logic signed [31:0] ONE  = 32'sh0001_0000;
        int wait_cycles;
        cycles = 0; idle_allowed = 1; hold_request = 0;
        rst_n = 1'b0; in_valid = 1'b0; in_beat = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: every action, saturation edges and each error case.
        send_op(ACT_READ,    0, 0, 0, 0, 0, 2'd0);
        send_op(ACT_LOAD,    MAXV, MINV, ONE, 0, 0, 2'd1);
        send_op(ACT_ADD,     MAXV, MINV, ONE, 0, 0, 2'd2);
        send_op(ACT_SUB,     MINV, MAXV, -ONE, 0, 0, 2'd0);
        send_op(ACT_NEGATE,  0, 0, 0, 0, 0, 2'd1);
        send_op(ACT_LOAD,    MINV, 3 * ONE, -5 * ONE, 0, 0, 2'd0);
        send_op(ACT_NEGATE,  0, 0, 0, 0, 0, 2'd0);
        send_op(ACT_INC,     0, 0, 0, 0, 0, 2'd2);
        send_op(ACT_DEC,     0, 0, 0, 0, 0, 2'd2);
        send_op(ACT_SCALE,   0, 0, 0, MAXV, 0, 2'd0);
        send_op(ACT_SCALE,   0, 0, 0, MINV, 0, 2'd1);
        send_op(ACT_DIVIDE,  0, 0, 0, 0, 0, 2'd0);
        send_op(ACT_LOAD,    -7 * ONE - 1, 9 * ONE, MAXV, 0, 0, 2'd0);
        send_op(ACT_DIVIDE,  0, 0, 0, 32'sh0000_4000, 0, 2'd1);
        send_op(ACT_DIVIDE,  0, 0, 0, MINV, 0, 2'd2);
        send_op(ACT_MODULO,  0, 0, 0, 0, 16'sd0, 2'd0);
        send_op(ACT_LOAD,    -7 * ONE - 1, 9 * ONE, MAXV, 0, 0, 2'd0);
        send_op(ACT_MODULO,  0, 0, 0, 0, -16'sd4, 2'd0);
        send_op(ACT_MODULO,  0, 0, 0, 0, -16'sd32768, 2'd1);
        send_op(ACT_LOAD,    ONE, 2 * ONE, 3 * ONE, 0, 0, 2'd0);
        send_op(ACT_CROSS,   4 * ONE, 5 * ONE, 6 * ONE, 0, 0, 2'd2);
        send_op(ACT_CROSS,   MAXV, MINV, MAXV, 0, 16'sd32767, 2'd0);
        send_op(ACT_COMPARE, 0, 0, 0, 0, 0, 2'd0);
        send_op(ACT_READ,    0, 0, 0, 0, 0, IDX_BAD);
        send_op(4'd15,       32'hffff_ffff, 0, 0, 32'hffff_ffff, 16'hffff, 2'd3);

        // Random beats; long receiver hold early on, a drain pause midway.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) hold_request = 1;
            if (i == 700) begin
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if (i == N_RANDOM - 200) idle_allowed = 0;
            send_beat(random_beat());
        end
        in_valid <= 1'b0;

        // Drain, then keep watching for stray beats.
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (100) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
